// ----- sv/lssp_pkg.sv -----
// Shared types and constants of the link-state shortest path engine.
package lssp_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned COST_W = 16;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned KIND_W = 3;

  localparam logic [DIST_W-1:0] DIST_ALL = '1;
  localparam logic [DIST_W-1:0] DIST_SAT = DIST_ALL - 22'd1;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COST   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UP     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RECOMP = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_PAIR    = 3'd1;
  localparam logic [ST_W-1:0] ST_IDUSED  = 3'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

  // One stored link.
  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [ID_W-1:0]   ident;
    logic [COST_W-1:0] cost;
    logic              up;
  } link_t;

  // Result item handed to the output register.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   path_link;
    logic [DIST_W-1:0] path_distance;
    logic              reachable;
    logic              last;
  } result_t;

endpackage

// ----- sv/lssp_link_store.sv -----
// Link table memory with one write port and one registered read port.
module lssp_link_store #(
  parameter int unsigned LINKS = 256,
  parameter int unsigned LA_W  = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [LA_W-1:0]   wr_addr,
  input  lssp_pkg::link_t   wr_data,
  input  logic [LA_W-1:0]   rd_addr,
  output lssp_pkg::link_t   rd_data
);

  lssp_pkg::link_t mem [LINKS];
  lssp_pkg::link_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

// ----- sv/lssp_node_store.sv -----
// Per-node distance and predecessor memories with a registered read port.
module lssp_node_store #(
  parameter int unsigned NODES = 64,
  parameter int unsigned NA_W  = 6,
  parameter int unsigned PW    = 9
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [NA_W-1:0]           wr_addr,
  input  logic [lssp_pkg::DIST_W-1:0] wr_dist,
  input  logic [PW-1:0]             wr_pred,
  input  logic [NA_W-1:0]           rd_addr,
  output logic [lssp_pkg::DIST_W-1:0] rd_dist,
  output logic [PW-1:0]             rd_pred
);

  logic [lssp_pkg::DIST_W-1:0] dist_mem [NODES];
  logic [PW-1:0]               pred_mem [NODES];
  logic [lssp_pkg::DIST_W-1:0] dist_r;
  logic [PW-1:0]               pred_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      pred_mem[wr_addr] <= wr_pred;
    end
    dist_r <= dist_mem[rd_addr];
    pred_r <= pred_mem[rd_addr];
  end

  assign rd_dist = dist_r;
  assign rd_pred = pred_r;

endmodule

// ----- sv/link_state_shortest_path_engine.sv -----
// Top level of the link-state shortest path engine: sequencer and shared unit.
//
//   channel  dir  fields
//   in_*     in   tuser: kind; tdata: src_node, dest_node, link_ident, link_cost
//   out_*    out  tdata: status, path_link, path_distance; tlast: last; tuser: reachable
//   cfg_*    in   self_node
//
// Edit items scan the link table once.
// A recompute first clears the node stores, then for each settled node scans
// every link and every node through the one adder/comparator. After reset
// the node stores are cleared before the first request is taken.
// in_tready is low while an item is worked on; a stalled result holds.
module link_state_shortest_path_engine #(
  parameter int unsigned NODES = 64,
  parameter int unsigned LINKS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // src_node[5:0] dest_node[11:6]
                                  // link_ident[27:12] link_cost[43:28]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0] path_link[18:3] path_distance[40:19]
  output logic        out_tlast,  // last
  output logic [0:0]  out_tuser,  // reachable
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata   // self_node
);

  localparam int unsigned NA_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LA_W = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int unsigned LC_W = $clog2(LINKS + 1);
  localparam int unsigned PW   = LC_W;
  localparam int unsigned NC_W = $clog2(NODES + 1);
  localparam logic [PW-1:0] PRED_NONE = '1;

  typedef enum logic [11:0] {
    S_CLR    = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_SCAN   = 12'b000000000100,
    S_SCANC  = 12'b000000001000,
    S_RSTART = 12'b000000010000,
    S_RELAX  = 12'b000000100000,
    S_RELAXC = 12'b000001000000,
    S_PICK   = 12'b000010000000,
    S_PICKC  = 12'b000100000000,
    S_RDN    = 12'b001000000000,
    S_RDL    = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [5:0] self_r;
  logic [2:0] kind_r;
  logic [5:0] src_r, dst_r;
  logic [15:0] id_r, cost_r;
  logic [LC_W-1:0] count_r, count_nxt;
  logic [LC_W-1:0] li_r, li_nxt;        // link scan index
  logic [NC_W-1:0] ni_r, ni_nxt;        // node scan index
  logic [NA_W-1:0] cur_r, cur_nxt;
  logic [lssp_pkg::DIST_W-1:0] base_r, base_nxt;
  logic [lssp_pkg::DIST_W-1:0] best_d_r, best_d_nxt;
  logic [NC_W-1:0] best_r, best_nxt;
  logic [NODES-1:0] vis_r, vis_nxt;
  logic pair_r, pair_nxt, idu_r, idu_nxt;
  logic [LA_W-1:0] at_r, at_nxt;
  logic [lssp_pkg::DIST_W-1:0] rdist_r, rdist_nxt;
  logic [NC_W-1:0] hops_r, hops_nxt;
  logic cont_r, cont_nxt;               // read path: more hops follow
  lssp_pkg::result_t res_r, res_nxt;
  logic ov_r, ov_nxt;

  // Memory ports.
  logic l_we;
  logic [LA_W-1:0] l_wa, l_ra;
  lssp_pkg::link_t l_wd, l_rd;
  logic n_we;
  logic [NA_W-1:0] n_wa, n_ra;
  logic [lssp_pkg::DIST_W-1:0] n_wd, n_rd;
  logic [PW-1:0] n_wp, n_rp;

  lssp_link_store #(.LINKS(LINKS), .LA_W(LA_W)) u_links (
    .clk(clk), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
    .rd_addr(l_ra), .rd_data(l_rd)
  );

  lssp_node_store #(.NODES(NODES), .NA_W(NA_W), .PW(PW)) u_nodes (
    .clk(clk), .wr_en(n_we), .wr_addr(n_wa), .wr_dist(n_wd), .wr_pred(n_wp),
    .rd_addr(n_ra), .rd_dist(n_rd), .rd_pred(n_rp)
  );

  // Shared unit: saturating add and one compare.
  logic [lssp_pkg::DIST_W:0] sum_w;
  logic [lssp_pkg::DIST_W-1:0] sum_sat;
  assign sum_w   = {1'b0, base_r} + {{(lssp_pkg::DIST_W + 1 - 16){1'b0}}, l_rd.cost};
  assign sum_sat = (sum_w > {1'b0, lssp_pkg::DIST_SAT}) ? lssp_pkg::DIST_SAT
                                                         : sum_w[lssp_pkg::DIST_W-1:0];

  logic dst_ok;
  assign dst_ok = ({{(32 - 6){1'b0}}, l_rd.dst} < NODES);

  function automatic logic [NA_W-1:0] nidx(input logic [5:0] v);
    logic [31:0] t;
    t = {{(32 - 6){1'b0}}, v};
    return t[NA_W-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    li_nxt = li_r;
    ni_nxt = ni_r;
    cur_nxt = cur_r;
    base_nxt = base_r;
    best_d_nxt = best_d_r;
    best_nxt = best_r;
    vis_nxt = vis_r;
    pair_nxt = pair_r;
    idu_nxt = idu_r;
    at_nxt = at_r;
    rdist_nxt = rdist_r;
    hops_nxt = hops_r;
    cont_nxt = cont_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    l_we = 1'b0;
    l_wa = li_r[LA_W-1:0];
    l_wd = '0;
    l_ra = li_r[LA_W-1:0];
    n_we = 1'b0;
    n_wa = ni_r[NA_W-1:0];
    n_wd = lssp_pkg::DIST_ALL;
    n_wp = PRED_NONE;
    n_ra = ni_r[NA_W-1:0];

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        n_we = 1'b1;
        ni_nxt = ni_r + 1'b1;
        if (ni_r == NC_W'(NODES - 1)) begin
          if (kind_r == lssp_pkg::KIND_RECOMP) begin
            state_nxt = S_RSTART;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_tvalid && !ov_r) begin
          li_nxt = '0;
          pair_nxt = 1'b0;
          idu_nxt = 1'b0;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          unique case (in_tuser) inside
            lssp_pkg::KIND_ADD, lssp_pkg::KIND_COST,
            lssp_pkg::KIND_DOWN, lssp_pkg::KIND_UP: begin
              state_nxt = S_SCAN;
            end
            lssp_pkg::KIND_RECOMP: begin
              ni_nxt = '0;
              vis_nxt = '0;
              state_nxt = S_CLR;
            end
            lssp_pkg::KIND_READ: begin
              state_nxt = S_RDN;
              hops_nxt = '0;
              ni_nxt = NC_W'(in_tdata[11:6]);
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Address li_r presented; data is checked next cycle.
        if (li_r >= count_r) begin
          state_nxt = S_OUT;
          if (kind_r == lssp_pkg::KIND_ADD) begin
            if (pair_r) res_nxt.status = lssp_pkg::ST_PAIR;
            else if (idu_r) res_nxt.status = lssp_pkg::ST_IDUSED;
            else if (count_r >= LC_W'(LINKS)) res_nxt.status = lssp_pkg::ST_FULL;
            else begin
              l_we = 1'b1;
              l_wa = count_r[LA_W-1:0];
              l_wd = '{src: src_r, dst: dst_r, ident: id_r, cost: cost_r, up: 1'b1};
              count_nxt = count_r + 1'b1;
            end
          end else if (!pair_r) begin
            res_nxt.status = lssp_pkg::ST_MISSING;
          end else begin
            l_we = 1'b1;
            l_wa = at_r;
            l_wd = l_rd;
            if (kind_r == lssp_pkg::KIND_COST) l_wd.cost = cost_r;
            else l_wd.up = (kind_r == lssp_pkg::KIND_UP);
          end
        end else begin
          state_nxt = S_SCANC;
        end
      end
      S_SCANC: begin
        if (!pair_r && l_rd.src == src_r && l_rd.dst == dst_r) begin
          pair_nxt = 1'b1;
          at_nxt = li_r[LA_W-1:0];
        end
        if (l_rd.ident == id_r) idu_nxt = 1'b1;
        li_nxt = li_r + 1'b1;
        state_nxt = S_SCAN;
        // After the last entry, reread the found entry for modify.
        if (li_r + 1'b1 >= count_r) begin
          l_ra = (!pair_r && l_rd.src == src_r && l_rd.dst == dst_r)
                 ? li_r[LA_W-1:0] : at_r;
        end else begin
          l_ra = LA_W'(li_r + 1'b1);
        end
      end
      S_RSTART: begin
        if ({{(32 - 6){1'b0}}, self_r} >= NODES) begin
          state_nxt = S_OUT;
        end else begin
          cur_nxt = nidx(self_r);
          base_nxt = '0;
          vis_nxt[nidx(self_r)] = 1'b1;
          n_we = 1'b1;
          n_wa = nidx(self_r);
          n_wd = '0;
          n_wp = PRED_NONE;
          li_nxt = '0;
          state_nxt = S_RELAX;
        end
      end
      S_RELAX: begin
        // Link li_r read; destination distance fetched next.
        if (li_r >= count_r) begin
          ni_nxt = '0;
          best_nxt = NC_W'(NODES);
          best_d_nxt = lssp_pkg::DIST_ALL;
          n_ra = '0;
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_RELAXC;
        end
      end
      S_RELAXC: begin
        // l_rd valid; fetch destination distance for the check in S_PICKC.
        n_ra = nidx(l_rd.dst);
        state_nxt = S_PICKC;
        ni_nxt = '1; // marks relax check in S_PICKC
      end
      S_PICKC: begin
        if (ni_r == '1) begin
          // Relax check for link li_r.
          if (l_rd.src == 6'(cur_r) && l_rd.up && dst_ok
              && !vis_r[nidx(l_rd.dst)] && n_rd >= sum_sat) begin
            n_we = 1'b1;
            n_wa = nidx(l_rd.dst);
            n_wd = sum_sat;
            n_wp = PW'(li_r);
          end
          li_nxt = li_r + 1'b1;
          l_ra = LA_W'(li_r + 1'b1);
          state_nxt = S_RELAX;
        end else begin
          // Pick check for node ni_r.
          if (!vis_r[ni_r[NA_W-1:0]] && n_rd <= best_d_r && n_rd != lssp_pkg::DIST_ALL) begin
            best_d_nxt = n_rd;
            best_nxt = ni_r;
          end
          ni_nxt = ni_r + 1'b1;
          n_ra = NA_W'(ni_r + 1'b1);
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (ni_r >= NC_W'(NODES)) begin
          if (best_r >= NC_W'(NODES)) begin
            state_nxt = S_OUT;
          end else begin
            cur_nxt = best_r[NA_W-1:0];
            base_nxt = best_d_r;
            vis_nxt[best_r[NA_W-1:0]] = 1'b1;
            li_nxt = '0;
            l_ra = '0;
            state_nxt = S_RELAX;
          end
        end else begin
          state_nxt = S_PICKC;
        end
      end
      S_RDN: begin
        // ni_r holds the node; its pred and distance become valid next.
        if (ni_r >= NC_W'(NODES)) begin
          if (hops_r == '0) begin
            res_nxt = '0;
            res_nxt.path_distance = lssp_pkg::DIST_ALL;
            res_nxt.last = 1'b1;
            state_nxt = S_OUT;
          end else if (!ov_r || out_tready) begin
            ov_nxt = 1'b1;
            res_nxt = res_r;
            res_nxt.last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          n_ra = ni_r[NA_W-1:0];
          cont_nxt = 1'b0;
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        // The predecessor link stays addressed while a hop waits.
        l_ra = n_rp[LA_W-1:0];
        if (!cont_r) begin
          // Node store data valid now.
          if (hops_r == '0) rdist_nxt = n_rd;
          if (n_rp >= count_r || hops_r >= NC_W'(NODES - 1)) begin
            if (hops_r == '0) begin
              res_nxt = '0;
              res_nxt.path_distance = n_rd;
              res_nxt.last = 1'b1;
              state_nxt = S_OUT;
            end else if (!ov_r || out_tready) begin
              res_nxt.last = 1'b1;
              ov_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            cont_nxt = 1'b1;
          end
        end else if (!ov_r || out_tready) begin
          // Link data valid; flush the previous hop and hold this one.
          if (hops_r != '0) ov_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.path_link = l_rd.ident;
          res_nxt.path_distance = rdist_r;
          res_nxt.reachable = 1'b1;
          hops_nxt = hops_r + 1'b1;
          ni_nxt = NC_W'(l_rd.src);
          state_nxt = S_RDN;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The read path keeps one hop in res_r and presents the previous one.
  lssp_pkg::result_t ob_r, ob_nxt;
  always_comb begin
    ob_nxt = ob_r;
    if (ov_nxt && (!ov_r || out_tready)) begin
      if (state_r == S_RDL && cont_r) ob_nxt = res_r;
      else ob_nxt = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ni_r <= '0;
      count_r <= '0;
      self_r <= '0;
      ov_r <= 1'b0;
      kind_r <= '0;
      vis_r <= '0;
    end else begin
      state_r <= state_nxt;
      ni_r <= ni_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      vis_r <= vis_nxt;
      if (cfg_we) self_r <= cfg_wdata;
      if (in_tvalid && in_tready) kind_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      src_r  <= in_tdata[5:0];
      dst_r  <= in_tdata[11:6];
      id_r   <= in_tdata[27:12];
      cost_r <= in_tdata[43:28];
    end
    li_r <= li_nxt;
    cur_r <= cur_nxt;
    base_r <= base_nxt;
    best_d_r <= best_d_nxt;
    best_r <= best_nxt;
    pair_r <= pair_nxt;
    idu_r <= idu_nxt;
    at_r <= at_nxt;
    rdist_r <= rdist_nxt;
    hops_r <= hops_nxt;
    cont_r <= cont_nxt;
    res_r <= res_nxt;
    ob_r <= ob_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, ob_r.path_distance, ob_r.path_link, ob_r.status};
  assign out_tlast  = ob_r.last;
  assign out_tuser  = ob_r.reachable;

  // A result waiting for the consumer holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // No new request is taken while a result is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  // The link count never exceeds the table size.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LC_W'(LINKS))
    else $error("link count overflow");

endmodule
